// ===== rtl/ansc_pkg.sv =====
`default_nettype none

package ansc_pkg;

  // default width of the free-running millisecond time base
  localparam int TIME_BITS_DEFAULT = 32;

  // width of the duration registers and of the check interval register
  localparam int CFG_TIME_W  = 32;
  localparam int CFG_CHECK_W = 16;
  localparam int CFG_INDEX_W = 3;

  // controller states
  localparam logic [1:0] ST_PROGRAM = 2'd0;
  localparam logic [1:0] ST_BEEPING = 2'd1;
  localparam logic [1:0] ST_SNOOZE  = 2'd2;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_NAP   = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NAP_DURATION    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SNOOZE_DURATION = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAY_MASK        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_HOUR      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_MINUTE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL  = 3'd5;

  // register reset values
  localparam logic [CFG_TIME_W-1:0]  NAP_DURATION_RST    = 32'd0;
  localparam logic [CFG_TIME_W-1:0]  SNOOZE_DURATION_RST = 32'd300000;
  localparam logic [CFG_CHECK_W-1:0] CHECK_INTERVAL_RST  = 16'd500;

  // proximity threshold for snooze
  localparam logic [15:0] NEAR_MM = 16'd150;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  day_of_week;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [15:0] range_mm;
    logic        stop_pressed;
  } item_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [1:0] alarm_state;
    logic       sensor_start;
  } result_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_TIME_W-1:0]  value;
  } cfg_write_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0]  nap_duration_ms;
    logic [CFG_TIME_W-1:0]  snooze_duration_ms;
    logic [6:0]             alarm_day_mask;
    logic [4:0]             alarm_hour;
    logic [5:0]             alarm_minute;
    logic [CFG_CHECK_W-1:0] alarm_check_interval_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ansc_stream_if.sv =====
`default_nettype none

interface ansc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/ansc_cfg_regs.sv =====
`default_nettype none

module ansc_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  ansc_stream_if.sink       cfg,
  output ansc_pkg::cfg_t    regs
);

  import ansc_pkg::*;

  // writes are registered directly, so the port never stalls
  assign cfg.ready = 1'b1;

  // register file, unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.nap_duration_ms         <= NAP_DURATION_RST;
      regs.snooze_duration_ms      <= SNOOZE_DURATION_RST;
      regs.alarm_day_mask          <= '0;
      regs.alarm_hour              <= '0;
      regs.alarm_minute            <= '0;
      regs.alarm_check_interval_ms <= CHECK_INTERVAL_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_NAP_DURATION:    regs.nap_duration_ms    <= cfg.data.value;
        REG_SNOOZE_DURATION: regs.snooze_duration_ms <= cfg.data.value;
        REG_DAY_MASK:        regs.alarm_day_mask     <= cfg.data.value[6:0];
        REG_ALARM_HOUR:      regs.alarm_hour         <= cfg.data.value[4:0];
        REG_ALARM_MINUTE:    regs.alarm_minute       <= cfg.data.value[5:0];
        REG_CHECK_INTERVAL: begin
          regs.alarm_check_interval_ms <= cfg.data.value[CFG_CHECK_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alarm_nap_snooze_controller.sv =====
`default_nettype none

// Alarm clock controller (programmed, beeping, snooze) driven by millisecond
// tick beats that carry the wall-clock reading, proximity range and stop
// button level; arm-nap and arm-alarm beats take the place of a tick. Every
// item beat yields exactly one result beat. The block takes one item per
// clock cycle while the result side does not stall; each item passes
// through the input register and then the result register, and a stall on
// the result side holds it in the input register. The rule logic between
// the two registers (a TIME_BITS increment of the time base feeding two
// subtracts and three compares) sets the cycle time. Configuration writes
// are registered directly and must be issued only while no item is in
// flight.
module alarm_nap_snooze_controller #(
  parameter int TIME_BITS = ansc_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ansc_stream_if.sink    item,
  ansc_stream_if.source  result,
  ansc_stream_if.sink    cfg
);

  import ansc_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

  cfg_t                 regs;

  // input register
  logic                 item_valid;
  item_t                item_q;
  logic                 advance;
  logic                 fire;

  // controller state
  logic [1:0]           mode_state;
  logic                 nap_armed;
  logic                 alarm_armed;
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] mark_ms;
  logic [TIME_BITS-1:0] last_check_ms;
  logic                 buzzer_level;

  logic [1:0]           mode_state_next;
  logic                 nap_armed_next;
  logic                 alarm_armed_next;
  logic [TIME_BITS-1:0] now_ms_next;
  logic [TIME_BITS-1:0] mark_ms_next;
  logic [TIME_BITS-1:0] last_check_ms_next;
  logic                 buzzer_level_next;
  logic                 started;

  // tick arithmetic
  logic [TIME_BITS-1:0] now_tick;
  logic [TIME_BITS-1:0] since_mark;
  logic [TIME_BITS-1:0] since_check;
  logic                 nap_due;
  logic                 snooze_due;
  logic                 check_due;
  logic [7:0]           day_mask_ext;
  logic                 sched_match;

  // output register
  logic                 out_valid;
  result_t              out_data;

  ansc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // handshake: result register frees up when empty or being drained
  assign advance    = !out_valid || result.ready;
  assign fire       = item_valid && advance;
  assign item.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      item_q <= item.data;
    end
  end

  // elapsed times against the advanced counter, wrapping
  assign now_tick    = now_ms + TIME_BITS'(1);
  assign since_mark  = now_tick - mark_ms;
  assign since_check = now_tick - last_check_ms;
  assign nap_due     = CMP_W'(since_mark) >= CMP_W'(regs.nap_duration_ms);
  assign snooze_due  = CMP_W'(since_mark) >= CMP_W'(regs.snooze_duration_ms);
  assign check_due   = CMP_W'(since_check) >= CMP_W'(regs.alarm_check_interval_ms);

  // weekday 7 falls on the padding bit and never matches
  assign day_mask_ext = {1'b0, regs.alarm_day_mask};
  assign sched_match  = day_mask_ext[item_q.day_of_week] &&
                        (regs.alarm_hour == item_q.hour_now) &&
                        (regs.alarm_minute == item_q.minute_now) &&
                        (item_q.second_now == 6'd0);

  // rules in priority order, each sees the state left by the one before
  always_comb begin
    mode_state_next    = mode_state;
    nap_armed_next     = nap_armed;
    alarm_armed_next   = alarm_armed;
    now_ms_next        = now_ms;
    mark_ms_next       = mark_ms;
    last_check_ms_next = last_check_ms;
    buzzer_level_next  = buzzer_level;
    started            = 1'b0;
    case (item_q.mode)
      MODE_NAP: begin
        mode_state_next = ST_PROGRAM;
        nap_armed_next  = 1'b1;
        mark_ms_next    = now_ms;
      end
      MODE_ALARM: begin
        mode_state_next  = ST_PROGRAM;
        alarm_armed_next = 1'b1;
      end
      MODE_TICK: begin
        now_ms_next = now_tick;
        // nap expiry
        if (mode_state_next == ST_PROGRAM && nap_armed && nap_due) begin
          mode_state_next   = ST_BEEPING;
          buzzer_level_next = 1'b1;
          started           = 1'b1;
        end
        // rate-limited weekly alarm check
        if (mode_state_next == ST_PROGRAM && alarm_armed && check_due) begin
          last_check_ms_next = now_tick;
          if (sched_match) begin
            mode_state_next   = ST_BEEPING;
            buzzer_level_next = 1'b1;
            started           = 1'b1;
          end
        end
        // snooze expiry
        if (mode_state_next == ST_SNOOZE && snooze_due) begin
          mode_state_next   = ST_BEEPING;
          buzzer_level_next = 1'b1;
          started           = 1'b1;
        end
        // hand close while beeping
        if (mode_state_next == ST_BEEPING && item_q.range_mm < NEAR_MM) begin
          mode_state_next   = ST_SNOOZE;
          mark_ms_next      = now_tick;
          buzzer_level_next = 1'b0;
        end
        // stop button level
        if (item_q.stop_pressed) begin
          mode_state_next   = ST_PROGRAM;
          nap_armed_next    = 1'b0;
          buzzer_level_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // state update, one item per fired cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state    <= ST_PROGRAM;
      nap_armed     <= 1'b0;
      alarm_armed   <= 1'b0;
      now_ms        <= '0;
      mark_ms       <= '0;
      last_check_ms <= '0;
      buzzer_level  <= 1'b0;
    end else if (fire) begin
      mode_state    <= mode_state_next;
      nap_armed     <= nap_armed_next;
      alarm_armed   <= alarm_armed_next;
      now_ms        <= now_ms_next;
      mark_ms       <= mark_ms_next;
      last_check_ms <= last_check_ms_next;
      buzzer_level  <= buzzer_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.buzzer_on    <= buzzer_level_next;
      out_data.alarm_state  <= mode_state_next;
      out_data.sensor_start <= started;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

`default_nettype wire
